>>> hw/rtl/ifba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifba_pkg
// Shared types and constants for the indexed file block allocator.
// ----------------------------------------------------------------------------
package ifba_pkg;

  localparam int BLOCKS_DEF          = 1024;
  localparam int MAX_DATA_BLOCKS_DEF = 63;

  localparam int SIZE_W   = 32;
  localparam int BBYTES_W = 13;
  localparam int BLK_W    = 10;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 6;
  localparam int STEP_W   = 5;
  localparam int LIM_W    = 11;

  localparam logic [BBYTES_W-1:0] BBYTES_RST = 13'd64;
  localparam logic [BBYTES_W-1:0] BBYTES_MIN = 13'd4;
  localparam logic [BBYTES_W-1:0] BBYTES_MAX = 13'd4096;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_EMIT,
    S_REJECT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_ok;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic reject;
    logic emit_last;
    logic slot_free;
  } stat_t;

endpackage

>>> hw/rtl/ifba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifba_ctrl
// Request sequencer: accept, divide, check, then emit results or one error.
// ----------------------------------------------------------------------------
module ifba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ifba_pkg::stat_t  stat,
  output ifba_pkg::cmd_t   cmd
);

  ifba_pkg::state_t state;
  ifba_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ifba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ifba_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ifba_pkg::S_DIV;
        end
      end
      ifba_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ifba_pkg::S_CHECK;
        end
      end
      ifba_pkg::S_CHECK: begin
        if (stat.reject) begin
          state_next = ifba_pkg::S_REJECT;
        end else begin
          state_next = ifba_pkg::S_EMIT;
        end
      end
      ifba_pkg::S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit_ok = 1'b1;
          if (stat.emit_last) begin
            state_next = ifba_pkg::S_IDLE;
          end
        end
      end
      ifba_pkg::S_REJECT: begin
        if (stat.slot_free) begin
          cmd.emit_err = 1'b1;
          state_next   = ifba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ifba_pkg::S_IDLE;
      end
    endcase
  end

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_ok && cmd.emit_err))
    else $error("ok and error result issued together");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ifba_pkg::S_DIV)
    else $error("accepted item did not start division");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_ok && stat.emit_last) || cmd.emit_err |=> state == ifba_pkg::S_IDLE)
    else $error("sequencer did not return to idle after final result");

endmodule

>>> hw/rtl/ifba_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifba_datapath
// Block size register, radix-2 divider, space checks, fill counters and
// output register.
// ----------------------------------------------------------------------------
module ifba_datapath #(
  parameter int BLOCKS          = ifba_pkg::BLOCKS_DEF,
  parameter int MAX_DATA_BLOCKS = ifba_pkg::MAX_DATA_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ifba_pkg::BBYTES_W-1:0]   cfg_data,
  input  logic [ifba_pkg::SIZE_W-1:0]     file_bytes,
  input  ifba_pkg::cmd_t                  cmd,
  output ifba_pkg::stat_t                 stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ifba_pkg::BLK_W-1:0]      block_number,
  output logic                            is_index,
  output logic [ifba_pkg::STAT_W-1:0]     status,
  output logic                            last
);

  localparam int CW = $clog2(BLOCKS + 1);
  localparam int BW = (CW > ifba_pkg::BLK_W) ? CW : ifba_pkg::BLK_W;
  localparam int QW = ifba_pkg::SIZE_W + 1;

  logic [ifba_pkg::BBYTES_W-1:0] block_bytes;
  logic [ifba_pkg::BBYTES_W-1:0] bsz;
  logic [ifba_pkg::BBYTES_W-1:0] divisor;
  logic [ifba_pkg::BBYTES_W-1:0] rem;
  logic [ifba_pkg::BBYTES_W:0]   trial;
  logic [ifba_pkg::SIZE_W-1:0]   quo;
  logic [ifba_pkg::STEP_W-1:0]   step;
  logic                          zero_size;
  logic [CW-1:0]                 free_count;
  logic [CW-1:0]                 next_blk;
  logic [ifba_pkg::CNT_W-1:0]    k;
  logic [ifba_pkg::LIM_W-1:0]    lim_raw;
  logic [ifba_pkg::LIM_W-1:0]    limit;
  logic                          no_space;
  logic                          too_large;
  logic [BW-1:0]                 blk_wide;
  logic                          out_load;

  always_comb begin
    bsz = block_bytes;
    if (block_bytes < ifba_pkg::BBYTES_MIN) begin
      bsz = ifba_pkg::BBYTES_MIN;
    end else if (block_bytes > ifba_pkg::BBYTES_MAX) begin
      bsz = ifba_pkg::BBYTES_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= ifba_pkg::BBYTES_RST;
    end else if (cfg_write) begin
      block_bytes <= cfg_data;
    end
  end

  assign trial = {rem, quo[ifba_pkg::SIZE_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor   <= bsz;
      rem       <= '0;
      quo       <= file_bytes - ifba_pkg::SIZE_W'(1);
      zero_size <= (file_bytes == '0);
      step      <= '0;
      k         <= '0;
    end else begin
      if (cmd.div_step) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= ifba_pkg::BBYTES_W'(trial - {1'b0, divisor});
          quo <= {quo[ifba_pkg::SIZE_W-2:0], 1'b1};
        end else begin
          rem <= trial[ifba_pkg::BBYTES_W-1:0];
          quo <= {quo[ifba_pkg::SIZE_W-2:0], 1'b0};
        end
        step <= step + ifba_pkg::STEP_W'(1);
      end
      if (cmd.emit_ok) begin
        k <= k + ifba_pkg::CNT_W'(1);
      end
    end
  end

  assign lim_raw   = divisor[ifba_pkg::BBYTES_W-1:2];
  assign limit     = (lim_raw > ifba_pkg::LIM_W'(MAX_DATA_BLOCKS))
                   ? ifba_pkg::LIM_W'(MAX_DATA_BLOCKS) : lim_raw;
  assign no_space  = zero_size || (({1'b0, quo} + QW'(2)) > QW'(free_count));
  assign too_large = ({1'b0, quo} + QW'(1)) > QW'(limit);

  assign stat.div_last  = (step == {ifba_pkg::STEP_W{1'b1}});
  assign stat.reject    = no_space || too_large;
  assign stat.emit_last = (k == quo[ifba_pkg::CNT_W-1:0] + ifba_pkg::CNT_W'(1));
  assign stat.slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= CW'(BLOCKS);
      next_blk   <= '0;
    end else if (cmd.emit_ok) begin
      free_count <= free_count - CW'(1);
      next_blk   <= next_blk + CW'(1);
    end
  end

  assign blk_wide = BW'(next_blk);
  assign out_load = cmd.emit_ok || cmd.emit_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ok) begin
      block_number <= blk_wide[ifba_pkg::BLK_W-1:0];
      is_index     <= (k == '0);
      status       <= ifba_pkg::ST_OK;
      last         <= stat.emit_last;
    end else if (cmd.emit_err) begin
      block_number <= '0;
      is_index     <= 1'b0;
      status       <= no_space ? ifba_pkg::ST_NO_SPACE : ifba_pkg::ST_TOO_LARGE;
      last         <= 1'b1;
    end
  end

  a_fill_sum: assert property (@(posedge clk) disable iff (rst)
    (QW'(free_count) + QW'(next_blk)) == QW'(BLOCKS))
    else $error("fill counters out of step");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_ok |-> free_count != '0)
    else $error("block issued with no free block left");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !out_load)
    else $error("output register overwritten while stalled");

endmodule

>>> hw/rtl/indexed_file_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_file_block_allocator_unit
// First-fit block allocator: one index block plus ceil(size / block size)
// data blocks per request.
// ----------------------------------------------------------------------------
// One item is taken at a time. It is accepted, goes through the radix-2
// divider that works out the data block count and then through the space and
// index-capacity checks, and then gives one result per cycle while the
// output register is free: n results in all (n is the data block count plus
// one on success, one on rejection). Blocks are never
// released, so the used blocks always form the prefix below a fill counter
// and first fit hands out consecutive numbers from it; no bitmap sweep or
// clearing pass is needed after reset. Block numbers are sent masked to ten
// bits. A size of zero, or a request larger than the free space, is rejected
// as no_space; one needing more data blocks than an index block can point at
// is rejected as too_large. Write block_bytes only while no item is in hand.
// ----------------------------------------------------------------------------
module indexed_file_block_allocator_unit #(
  parameter int BLOCKS          = ifba_pkg::BLOCKS_DEF,
  parameter int MAX_DATA_BLOCKS = ifba_pkg::MAX_DATA_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ifba_pkg::BBYTES_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ifba_pkg::SIZE_W-1:0]    file_bytes,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ifba_pkg::BLK_W-1:0]     block_number,
  output logic                           is_index,
  output logic [ifba_pkg::STAT_W-1:0]    status,
  output logic                           last
);

  ifba_pkg::cmd_t  cmd;
  ifba_pkg::stat_t stat;

  ifba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ifba_datapath #(
    .BLOCKS          (BLOCKS),
    .MAX_DATA_BLOCKS (MAX_DATA_BLOCKS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .file_bytes   (file_bytes),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .block_number (block_number),
    .is_index     (is_index),
    .status       (status),
    .last         (last)
  );

endmodule
